// ===== hw/rtl/gsig_pkg.sv =====
// Shared types and constants for the grid strip index generator.
// No dependencies; gsig_cfg, gsig_seq, gsig_idx and the top level import this package.
package gsig_pkg;

	localparam int COL_W  = 9;   // column counters, vertices per row, row factor
	localparam int ROW_W  = 8;   // strip row counter
	localparam int POS_W  = 17;  // position within the strip sequence
	localparam int PROD_W = 18;  // column + width * row factor
	localparam int ADDR_W = 4;   // APB byte address

	// Configuration as seen by the datapath, with derived strip geometry
	typedef struct packed {
		logic [7:0]       column_blocks;
		logic [7:0]       row_blocks;
		logic [15:0]      base_offset;
		logic [COL_W-1:0] w;         // vertices per row
		logic [POS_W-1:0] last_pos;  // position of the final index
	} cfg_t;

	// Operands of one index, handed from the sequencer to the index stage
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] factor;
		logic [COL_W-1:0] w;
		logic             last;
	} op_t;

endpackage

// ===== hw/rtl/gsig_if.sv =====
// Valid/ready channel interfaces of the grid strip index generator.
// Request beats carry the restart flag, response beats carry one index.
// No dependencies.
interface gsig_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface gsig_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_index;
	logic [15:0] vertex_index;
	logic        last;

	modport source (output valid, output raw_index, output vertex_index, output last,
		input ready);
	modport sink   (input valid, input raw_index, input vertex_index, input last,
		output ready);
endinterface

// ===== hw/rtl/gsig_cfg.sv =====
// APB register file: column_blocks, row_blocks, base_offset.
// Also keeps the vertices per row and the last strip position, updated on write.
// Depends on gsig_pkg.
module gsig_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gsig_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output gsig_pkg::cfg_t              cfg
);
	import gsig_pkg::*;

	localparam logic [1:0] REG_COLUMN_BLOCKS = 2'd0;
	localparam logic [1:0] REG_ROW_BLOCKS    = 2'd1;
	localparam logic [1:0] REG_BASE_OFFSET   = 2'd2;

	logic [7:0]       column_blocks_q;
	logic [7:0]       row_blocks_q;
	logic [15:0]      base_offset_q;
	logic [COL_W-1:0] w_q;
	logic [POS_W-1:0] last_pos_q;
	logic [1:0]       reg_sel;
	logic             wr_en;
	logic [7:0]       geo_cols;
	logic [7:0]       geo_rows;

	// Vertices per row; a zero column count acts as one
	function automatic logic [COL_W-1:0] width_of(input logic [7:0] cols);
		logic [7:0] c;
		c = (cols == 8'd0) ? 8'd1 : cols;
		return {1'b0, c} + COL_W'(1);
	endfunction

	// Last position: 2*w*rows + 2*(rows-1) - 1; a zero row count acts as one
	function automatic logic [POS_W-1:0] last_of(input logic [7:0] cols,
		input logic [7:0] rows);
		logic [7:0]       r;
		logic [POS_W-1:0] prod;
		logic [POS_W-1:0] total;
		r     = (rows == 8'd0) ? 8'd1 : rows;
		prod  = POS_W'(width_of(cols)) * POS_W'(r);
		total = (prod << 1) + POS_W'({r - 8'd1, 1'b0});
		return total - POS_W'(1);
	endfunction

	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// New geometry as it stands after this write
	always_comb begin
		geo_cols = column_blocks_q;
		geo_rows = row_blocks_q;
		if (wr_en && reg_sel == REG_COLUMN_BLOCKS) begin
			geo_cols = pwdata[7:0];
		end
		if (wr_en && reg_sel == REG_ROW_BLOCKS) begin
			geo_rows = pwdata[7:0];
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_blocks_q <= 8'd1;
			row_blocks_q    <= 8'd1;
			base_offset_q   <= 16'd0;
			w_q             <= COL_W'(2);
			last_pos_q      <= POS_W'(3);
		end else if (wr_en) begin
			case (reg_sel)
				REG_COLUMN_BLOCKS: column_blocks_q <= pwdata[7:0];
				REG_ROW_BLOCKS:    row_blocks_q    <= pwdata[7:0];
				REG_BASE_OFFSET:   base_offset_q   <= pwdata[15:0];
				default: ;
			endcase
			w_q        <= width_of(geo_cols);
			last_pos_q <= last_of(geo_cols, geo_rows);
		end
	end

	// Read back
	always_comb begin
		case (reg_sel)
			REG_COLUMN_BLOCKS: prdata = {24'd0, column_blocks_q};
			REG_ROW_BLOCKS:    prdata = {24'd0, row_blocks_q};
			REG_BASE_OFFSET:   prdata = {16'd0, base_offset_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg.column_blocks = column_blocks_q;
	assign cfg.row_blocks    = row_blocks_q;
	assign cfg.base_offset   = base_offset_q;
	assign cfg.w             = w_q;
	assign cfg.last_pos      = last_pos_q;

endmodule

// ===== hw/rtl/gsig_seq.sv =====
// Strip sequencer: column, row and position counters, stage 1 operand register.
// Takes request beats and hands index operands to the index stage.
// Depends on gsig_pkg and gsig_req_if.
module gsig_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  gsig_pkg::cfg_t cfg,
	gsig_req_if.sink       req,
	output gsig_pkg::op_t  op_s1,
	output logic           valid_s1,
	input  logic           op_ready
);
	import gsig_pkg::*;

	logic [COL_W-1:0] lower_q, upper_q;
	logic [ROW_W-1:0] row_q;
	logic [POS_W-1:0] pos_q;
	logic [COL_W-1:0] lower_e, upper_e, lower_n, upper_n;
	logic [ROW_W-1:0] row_e, row_n;
	logic [POS_W-1:0] pos_e, pos_n;
	logic             first;
	logic             take;
	op_t              op;

	assign req.ready = !valid_s1 || op_ready;
	assign take      = req.valid && req.ready;

	// Next counters and operands for one beat
	always_comb begin
		lower_e = req.restart ? '0 : lower_q;
		upper_e = req.restart ? '0 : upper_q;
		row_e   = req.restart ? '0 : row_q;
		pos_e   = req.restart ? '0 : pos_q;
		first   = (pos_e == '0);
		lower_n = lower_e;
		upper_n = upper_e;
		row_n   = row_e;
		op      = '0;
		op.w    = cfg.w;
		priority if (!first && upper_e == cfg.w) begin
			// repeat the last upper vertex
			op.col    = upper_e - COL_W'(1);
			op.factor = {1'b0, row_e};
			upper_n   = '0;
		end else if (!first && lower_e == cfg.w && upper_e == '0) begin
			// step to the next row, repeat its first lower vertex
			lower_n   = '0;
			row_n     = row_e + ROW_W'(1);
			op.col    = '0;
			op.factor = {1'b0, row_n} + COL_W'(1);
		end else if (!pos_e[0]) begin
			op.col    = lower_e;
			op.factor = {1'b0, row_e} + COL_W'(1);
			lower_n   = lower_e + COL_W'(1);
		end else begin
			op.col    = upper_e;
			op.factor = {1'b0, row_e};
			upper_n   = upper_e + COL_W'(1);
		end
		op.last = (pos_e >= cfg.last_pos);
		pos_n   = pos_e + POS_W'(1);
		if (op.last) begin
			lower_n = '0;
			upper_n = '0;
			row_n   = '0;
			pos_n   = '0;
		end
	end

	// Advance the counters on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
			row_q   <= '0;
			pos_q   <= '0;
		end else if (take) begin
			lower_q <= lower_n;
			upper_q <= upper_n;
			row_q   <= row_n;
			pos_q   <= pos_n;
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Stage 1 operands
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op;
		end
	end

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && op.last |=> pos_q == '0 && lower_q == '0 && upper_q == '0 && row_q == '0)
		else $error("sequence not cleared after last index");

	a_restart_first: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.restart |-> op.col == '0 && op.factor == COL_W'(1))
		else $error("restart beat does not start at the first index");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !op_ready |=> valid_s1 && $stable(op_s1))
		else $error("stage 1 operands lost under stall");
`endif

endmodule

// ===== hw/rtl/gsig_idx.sv =====
// Index stage: column + width * row factor, base offset add, response register.
// Drives the response channel.
// Depends on gsig_pkg and gsig_rsp_if.
module gsig_idx #(
	parameter int INDEX_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gsig_pkg::cfg_t cfg,
	input  gsig_pkg::op_t  op_s1,
	input  logic           valid_s1,
	output logic           op_ready,
	gsig_rsp_if.source     rsp
);
	import gsig_pkg::*;

	logic [PROD_W-1:0]      full_idx;
	logic [INDEX_WIDTH-1:0] idx;
	logic [INDEX_WIDTH-1:0] vidx;
	logic                   valid_s2;
	logic [15:0]            raw_s2;
	logic [15:0]            vertex_s2;
	logic                   last_s2;

	assign op_ready = !valid_s2 || rsp.ready;

	// Index arithmetic wraps at the index width
	always_comb begin
		full_idx = PROD_W'(op_s1.col) + PROD_W'(op_s1.w) * PROD_W'(op_s1.factor);
		idx      = INDEX_WIDTH'(full_idx);
		vidx     = idx + INDEX_WIDTH'(cfg.base_offset);
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (op_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Response payload, held while the receiver stalls
	always_ff @(posedge clk) begin
		if (op_ready && valid_s1) begin
			raw_s2    <= 16'(idx);
			vertex_s2 <= 16'(vidx);
			last_s2   <= op_s1.last;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.raw_index    = raw_s2;
	assign rsp.vertex_index = vertex_s2;
	assign rsp.last         = last_s2;

endmodule

// ===== hw/rtl/grid_strip_index_generator.sv =====
// Top level of the grid strip index generator.
// Depends on gsig_pkg, gsig_if, gsig_cfg, gsig_seq and gsig_idx.
//
// Each request beat (req) returns one response beat (rsp) carrying the next
// vertex index of a triangle strip over a grid of column_blocks x row_blocks
// cells: raw_index, vertex_index = raw_index + base_offset, and last on the
// final index of the strip. The sequence restarts after last, or before a
// beat whose restart flag is set.
// Registers sit on an APB port: column_blocks at 0x0, row_blocks at 0x4,
// base_offset at 0x8. Write them only while no beat is in flight.
// A response is valid once its request has passed the counter update and operand
// register, then the multiply-add and result register. Throughput: one beat per
// cycle while rsp does not stall, bounded by the counter update.
// When rsp stalls, the result register and the operand register both hold and
// req.ready drops once both are full; no beat is lost.
// Reset clears the counters and both stages; registers return to one column,
// one row and a zero offset.
module grid_strip_index_generator #(
	parameter int INDEX_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	gsig_req_if.sink                    req,
	gsig_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gsig_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import gsig_pkg::*;

	cfg_t cfg;
	op_t  op_s1;
	logic valid_s1;
	logic op_ready;

	gsig_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gsig_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.req      (req),
		.op_s1    (op_s1),
		.valid_s1 (valid_s1),
		.op_ready (op_ready)
	);

	gsig_idx #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_idx (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.op_s1    (op_s1),
		.valid_s1 (valid_s1),
		.op_ready (op_ready),
		.rsp      (rsp)
	);

endmodule
